// ===== rtl/glk_pkg.sv =====
package glk_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ANG_FRAC      = 24;
    localparam int TRIG_FRAC     = 30;
    localparam int CORDIC_STEPS  = 28;
    localparam int RNG_SHIFT     = 4;

    localparam int IW = 27;
    localparam int ZW = 34;
    localparam int XW = 33;
    localparam int LW = 32;
    localparam int VW = 34;
    localparam int SW = 58;
    localparam int RB = 29;

    localparam logic signed [XW-1:0] CORDIC_GAIN   = 33'sd652032874;
    localparam logic signed [LW-1:0] ORBIT_RAD_FX  = 32'sd172703744;
    localparam logic signed [LW-1:0] PLANET_RAD_FX = 32'sd26124849;
    localparam logic [23:0]          RANGE_MAX     = 24'd12800000;

    localparam logic signed [ZW-1:0] HALF_ANG    = ZW'(64'd180 << ANG_FRAC);
    localparam logic signed [ZW-1:0] QUARTER_ANG = ZW'(64'd90 << ANG_FRAC);

    localparam logic CFG_LAT = 1'b0;
    localparam logic CFG_LON = 1'b1;

    localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
        31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
        31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
        31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
        31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
        31'd115, 31'd57, 31'd29, 31'd14, 31'd7
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_state_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [ZW-1:0] base;
        logic                 bypass;
    } vec_state_t;

    typedef struct packed {
        logic [SW-1:0] n;
        logic [SW-1:0] r;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [LW-1:0] clat;
        logic signed [LW-1:0] slat;
        logic signed [LW-1:0] clon;
        logic signed [LW-1:0] slon;
    } trig_t;

    function automatic logic signed [LW-1:0] fx_mul(input logic signed [LW-1:0] a,
                                                    input logic signed [LW-1:0] b);
        logic signed [2*LW-1:0] p;
        p = a * b;
        return LW'(p >>> TRIG_FRAC);
    endfunction

endpackage

// ===== rtl/geo_look_angle_unit.sv =====
// Throughput: one item per cycle; the CORDIC and square-root cell chains are fully pipelined.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default observer
// position; datapath registers are not reset.
module geo_look_angle_unit #(
    parameter int FRAC_BITS = glk_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [24:0] s_raan,
    input  logic [24:0] s_mean_anomaly,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [24:0] m_azimuth,
    output logic [23:0] m_elevation,
    output logic [23:0] m_slant_range,
    output logic        m_visible,
    output logic [2:0]  m_compass_sector,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int CS  = glk_pkg::CORDIC_STEPS;
    localparam int RB  = glk_pkg::RB;
    localparam int LW  = glk_pkg::LW;
    localparam int VW  = glk_pkg::VW;
    localparam int ZW  = glk_pkg::ZW;
    localparam int SW  = glk_pkg::SW;
    localparam int IW  = glk_pkg::IW;
    localparam int OW  = ZW + 1;
    localparam int RBW = RB + 1;
    localparam int LAT = 2 * CS + RB + 20;
    localparam int SHI = glk_pkg::ANG_FRAC - FRAC_BITS;

    localparam logic [23:0] LAT_RST = 24'(((64'd5140 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [24:0] LON_RST = 25'(-(((64'sd16 <<< FRAC_BITS) + 64'sd50) / 64'sd100));
    localparam logic signed [OW-1:0] RND    = OW'((64'd1 << SHI) >> 1);
    localparam logic signed [OW-1:0] TURN_O = OW'(64'd360 << FRAC_BITS);
    localparam logic signed [OW-1:0] S45    = OW'(64'd45 << FRAC_BITS);
    localparam logic signed [OW-1:0] S45H   = OW'((64'd45 << FRAC_BITS) >> 1);

    function automatic logic [SW-1:0] sq(input logic signed [LW-1:0] a);
        logic signed [2*LW-1:0] p;
        p = a * a;
        return p[SW-1:0];
    endfunction

    function automatic glk_pkg::vec_state_t vec_init(input logic signed [VW-1:0] y,
                                                     input logic signed [VW-1:0] x);
        glk_pkg::vec_state_t s;
        s.x    = x;
        s.y    = y;
        s.z    = '0;
        s.base = '0;
        if (x < 0) begin
            s.base = (y >= 0) ? glk_pkg::HALF_ANG : -glk_pkg::HALF_ANG;
            s.x    = -x;
            s.y    = -y;
        end
        s.bypass = (s.y == '0);
        return s;
    endfunction

    logic adv;
    logic vld_reg [LAT-1];
    logic m_valid_reg;

    logic [23:0] lat_reg;
    logic [24:0] lon_reg;

    logic signed [IW-1:0] in_sum_reg, in_lat_reg, in_lon_reg;

    logic signed [ZW-1:0] z_sat, z_lat, z_olon;
    logic                 f_sat, f_lat, f_olon;

    glk_pkg::rot_state_t rot_sat [CS+1];
    glk_pkg::rot_state_t rot_lat [CS+1];
    glk_pkg::rot_state_t rot_lon [CS+1];

    logic signed [LW-1:0] cs_reg, ss_reg;
    glk_pkg::trig_t       trig_reg [6];

    logic signed [LW-1:0] xs1_reg, ys1_reg, rc1_reg, zo1_reg;
    logic signed [LW-1:0] xs2_reg, ys2_reg, zo2_reg, xo2_reg, yo2_reg;
    logic signed [LW-1:0] dx3_reg, dy3_reg, dz3_reg;
    logic signed [LW-1:0] pe1_reg, pe2_reg, ph1_reg, ph2_reg, dz4_reg;
    logic [SW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [LW-1:0] east5_reg, h5_reg, dz5_reg;
    logic [SW-1:0]        sqsum_reg;
    logic signed [LW-1:0] pn1_reg, pn2_reg, pu1_reg, pu2_reg, east6_reg;
    logic signed [LW-1:0] east7_reg, north7_reg, up7_reg;
    logic [SW-1:0]        sqe_reg, sqn_reg, hsum_reg;

    glk_pkg::sqrt_state_t rsq [RB+1];
    glk_pkg::sqrt_state_t hsq [RB+1];
    glk_pkg::vec_state_t  vaz [CS+1];
    glk_pkg::vec_state_t  vel [CS+1];
    glk_pkg::vec_state_t  paz_reg, pel_reg;

    logic [23:0]          rng_reg;
    logic [23:0]          rng_dly_reg [CS+5];
    logic signed [LW-1:0] up_dly_reg [RB+2];
    logic signed [ZW-1:0] az_reg, el_reg;
    logic signed [ZW-1:0] az_dly_reg [RB+2];

    logic signed [OW-1:0] azo_reg, elo_reg;
    logic [23:0]          rngf_reg;

    logic [24:0] m_azimuth_reg;
    logic [23:0] m_elevation_reg, m_slant_range_reg;
    logic        m_visible_reg;
    logic [2:0]  m_compass_sector_reg;

    logic [RBW-1:0]       rng_rnd;
    logic [23:0]          rng_next;
    logic signed [OW-1:0] az_rnd, el_rnd, sec_num;
    logic [3:0]           sec_cnt;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= LAT_RST;
            lon_reg <= LON_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                glk_pkg::CFG_LAT: lat_reg <= cfg_data[23:0];
                glk_pkg::CFG_LON: lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT - 1; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < LAT - 1; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[LAT-2];
        end
    end

    glk_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_sat (
        .aclk(aclk), .en(adv), .v(in_sum_reg), .z(z_sat), .flip(f_sat)
    );
    glk_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_lat (
        .aclk(aclk), .en(adv), .v(in_lat_reg), .z(z_lat), .flip(f_lat)
    );
    glk_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_lon (
        .aclk(aclk), .en(adv), .v(in_lon_reg), .z(z_olon), .flip(f_olon)
    );

    assign rot_sat[0] = '{x: glk_pkg::CORDIC_GAIN, y: '0, z: z_sat, flip: f_sat};
    assign rot_lat[0] = '{x: glk_pkg::CORDIC_GAIN, y: '0, z: z_lat, flip: f_lat};
    assign rot_lon[0] = '{x: glk_pkg::CORDIC_GAIN, y: '0, z: z_olon, flip: f_olon};

    for (genvar i = 0; i < CS; i++) begin : g_rot
        glk_rot_cell #(.IDX(i)) u_sat (.aclk(aclk), .en(adv), .d(rot_sat[i]), .q(rot_sat[i+1]));
        glk_rot_cell #(.IDX(i)) u_lat (.aclk(aclk), .en(adv), .d(rot_lat[i]), .q(rot_lat[i+1]));
        glk_rot_cell #(.IDX(i)) u_lon (.aclk(aclk), .en(adv), .d(rot_lon[i]), .q(rot_lon[i+1]));
    end

    assign rsq[0] = '{n: sqsum_reg, r: '0};
    assign hsq[0] = '{n: hsum_reg, r: '0};
    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        glk_sqrt_cell #(.IDX(i)) u_rng (.aclk(aclk), .en(adv), .d(rsq[i]), .q(rsq[i+1]));
        glk_sqrt_cell #(.IDX(i)) u_hz (.aclk(aclk), .en(adv), .d(hsq[i]), .q(hsq[i+1]));
    end

    assign vaz[0] = paz_reg;
    assign vel[0] = pel_reg;
    for (genvar i = 0; i < CS; i++) begin : g_vec
        glk_vec_cell #(.IDX(i)) u_az (.aclk(aclk), .en(adv), .d(vaz[i]), .q(vaz[i+1]));
        glk_vec_cell #(.IDX(i)) u_el (.aclk(aclk), .en(adv), .d(vel[i]), .q(vel[i+1]));
    end

    always_comb begin
        rng_rnd  = {1'b0, rsq[RB].r[RB-1:0]} + RBW'(1 << (glk_pkg::RNG_SHIFT - 1));
        rng_rnd  = rng_rnd >> glk_pkg::RNG_SHIFT;
        rng_next = (rng_rnd > RBW'(glk_pkg::RANGE_MAX)) ? glk_pkg::RANGE_MAX : rng_rnd[23:0];

        az_rnd = (OW'(az_dly_reg[RB+1]) + RND) >>> SHI;
        if (az_rnd < 0) begin
            az_rnd = az_rnd + TURN_O;
        end else if (az_rnd >= TURN_O) begin
            az_rnd = az_rnd - TURN_O;
        end
        el_rnd = (OW'(el_reg) + RND) >>> SHI;

        sec_num = azo_reg + S45H;
        sec_cnt = '0;
        for (int k = 1; k <= 8; k++) begin
            if (sec_num >= OW'(k) * S45) begin
                sec_cnt = sec_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_sum_reg <= $signed(IW'(26'(s_raan) + 26'(s_mean_anomaly)));
            in_lat_reg <= IW'($signed(lat_reg));
            in_lon_reg <= IW'($signed(lon_reg));

            cs_reg <= LW'(rot_sat[CS].flip ? -rot_sat[CS].x : rot_sat[CS].x);
            ss_reg <= LW'(rot_sat[CS].flip ? -rot_sat[CS].y : rot_sat[CS].y);
            trig_reg[0].clat <= LW'(rot_lat[CS].flip ? -rot_lat[CS].x : rot_lat[CS].x);
            trig_reg[0].slat <= LW'(rot_lat[CS].flip ? -rot_lat[CS].y : rot_lat[CS].y);
            trig_reg[0].clon <= LW'(rot_lon[CS].flip ? -rot_lon[CS].x : rot_lon[CS].x);
            trig_reg[0].slon <= LW'(rot_lon[CS].flip ? -rot_lon[CS].y : rot_lon[CS].y);
            for (int i = 1; i < 6; i++) begin
                trig_reg[i] <= trig_reg[i-1];
            end

            xs1_reg <= glk_pkg::fx_mul(glk_pkg::ORBIT_RAD_FX, cs_reg);
            ys1_reg <= glk_pkg::fx_mul(glk_pkg::ORBIT_RAD_FX, ss_reg);
            rc1_reg <= glk_pkg::fx_mul(glk_pkg::PLANET_RAD_FX, trig_reg[0].clat);
            zo1_reg <= glk_pkg::fx_mul(glk_pkg::PLANET_RAD_FX, trig_reg[0].slat);

            xo2_reg <= glk_pkg::fx_mul(rc1_reg, trig_reg[1].clon);
            yo2_reg <= glk_pkg::fx_mul(rc1_reg, trig_reg[1].slon);
            xs2_reg <= xs1_reg;
            ys2_reg <= ys1_reg;
            zo2_reg <= zo1_reg;

            dx3_reg <= xs2_reg - xo2_reg;
            dy3_reg <= ys2_reg - yo2_reg;
            dz3_reg <= -zo2_reg;

            pe1_reg <= glk_pkg::fx_mul(dy3_reg, trig_reg[3].clon);
            pe2_reg <= glk_pkg::fx_mul(dx3_reg, trig_reg[3].slon);
            ph1_reg <= glk_pkg::fx_mul(dx3_reg, trig_reg[3].clon);
            ph2_reg <= glk_pkg::fx_mul(dy3_reg, trig_reg[3].slon);
            sqx_reg <= sq(dx3_reg);
            sqy_reg <= sq(dy3_reg);
            sqz_reg <= sq(dz3_reg);
            dz4_reg <= dz3_reg;

            east5_reg <= pe1_reg - pe2_reg;
            h5_reg    <= ph1_reg + ph2_reg;
            sqsum_reg <= sqx_reg + sqy_reg + sqz_reg;
            dz5_reg   <= dz4_reg;

            pn1_reg   <= glk_pkg::fx_mul(dz5_reg, trig_reg[5].clat);
            pn2_reg   <= glk_pkg::fx_mul(h5_reg, trig_reg[5].slat);
            pu1_reg   <= glk_pkg::fx_mul(h5_reg, trig_reg[5].clat);
            pu2_reg   <= glk_pkg::fx_mul(dz5_reg, trig_reg[5].slat);
            east6_reg <= east5_reg;

            north7_reg <= pn1_reg - pn2_reg;
            up7_reg    <= pu1_reg + pu2_reg;
            east7_reg  <= east6_reg;

            sqe_reg  <= sq(east7_reg);
            sqn_reg  <= sq(north7_reg);
            hsum_reg <= sqe_reg + sqn_reg;

            paz_reg <= vec_init(VW'(east7_reg), VW'(north7_reg));
            az_reg  <= vaz[CS].bypass ? vaz[CS].base : vaz[CS].base + vaz[CS].z;

            up_dly_reg[0] <= up7_reg;
            for (int i = 1; i < RB + 2; i++) begin
                up_dly_reg[i] <= up_dly_reg[i-1];
            end
            pel_reg <= vec_init(VW'(up_dly_reg[RB+1]), $signed(VW'(hsq[RB].r[RB-1:0])));
            el_reg  <= vel[CS].bypass ? vel[CS].base : vel[CS].base + vel[CS].z;

            rng_reg        <= rng_next;
            rng_dly_reg[0] <= rng_reg;
            for (int i = 1; i < CS + 5; i++) begin
                rng_dly_reg[i] <= rng_dly_reg[i-1];
            end

            az_dly_reg[0] <= az_reg;
            for (int i = 1; i < RB + 2; i++) begin
                az_dly_reg[i] <= az_dly_reg[i-1];
            end

            azo_reg  <= az_rnd;
            elo_reg  <= el_rnd;
            rngf_reg <= rng_dly_reg[CS+4];

            m_azimuth_reg        <= azo_reg[24:0];
            m_elevation_reg      <= elo_reg[23:0];
            m_slant_range_reg    <= rngf_reg;
            m_visible_reg        <= (elo_reg > 0);
            m_compass_sector_reg <= sec_cnt[2:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_azimuth        = m_azimuth_reg;
    assign m_elevation      = m_elevation_reg;
    assign m_slant_range    = m_slant_range_reg;
    assign m_visible        = m_visible_reg;
    assign m_compass_sector = m_compass_sector_reg;

endmodule

// ===== rtl/glk_reduce.sv =====
module glk_reduce #(
    parameter int FRAC_BITS = glk_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [glk_pkg::IW-1:0]     v,
    output logic signed [glk_pkg::ZW-1:0]     z,
    output logic                              flip
);

    localparam int     QW   = 11;
    localparam int     RW   = 35;
    localparam int     WW   = RW + 1;
    localparam int     RSH  = 40;
    localparam int     SHI  = glk_pkg::ANG_FRAC - FRAC_BITS;
    localparam longint TURN = 64'd360 << FRAC_BITS;
    localparam longint HALF = 64'd180 << FRAC_BITS;
    localparam longint RCP  = (64'sd1 <<< RSH) / TURN;

    logic [glk_pkg::IW-1:0]          mag_reg;
    logic [QW-1:0]                   q_reg;
    logic                            neg1_reg, neg2_reg;
    logic [RW-1:0]                   rem_reg, fm_reg;
    logic signed [glk_pkg::ZW-1:0]   zi_reg, z_reg;
    logic                            flip_reg;

    logic [glk_pkg::IW-1:0]          mag_next;
    logic [63:0]                     prod;
    logic [RW-1:0]                   rc, fm_next;
    logic signed [WW-1:0]            w;
    logic signed [glk_pkg::ZW-1:0]   z_next;
    logic                            flip_next;

    always_comb begin
        mag_next = (v < 0) ? glk_pkg::IW'(-v) : glk_pkg::IW'(v);
        prod     = 64'(mag_next) * 64'(RCP);
        rc       = (rem_reg >= RW'(TURN)) ? rem_reg - RW'(TURN) : rem_reg;
        if (neg2_reg) begin
            fm_next = (rc == '0) ? '0 : RW'(TURN) - rc;
        end else begin
            fm_next = rc;
        end
        w = $signed({1'b0, fm_reg});
        if (fm_reg > RW'(HALF)) begin
            w = w - WW'(TURN);
        end
        z_next    = zi_reg;
        flip_next = 1'b0;
        if (zi_reg > glk_pkg::QUARTER_ANG) begin
            z_next    = zi_reg - glk_pkg::HALF_ANG;
            flip_next = 1'b1;
        end else if (zi_reg < -glk_pkg::QUARTER_ANG) begin
            z_next    = zi_reg + glk_pkg::HALF_ANG;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            q_reg    <= QW'(prod >> RSH);
            neg1_reg <= (v < 0);
            rem_reg  <= RW'(mag_reg) - RW'(q_reg) * RW'(TURN);
            neg2_reg <= neg1_reg;
            fm_reg   <= fm_next;
            zi_reg   <= glk_pkg::ZW'(w) <<< SHI;
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign z    = z_reg;
    assign flip = flip_reg;

endmodule

// ===== rtl/glk_rot_cell.sv =====
module glk_rot_cell #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                en,
    input  glk_pkg::rot_state_t d,
    output glk_pkg::rot_state_t q
);

    glk_pkg::rot_state_t state_reg, state_next;
    logic signed [glk_pkg::XW-1:0] tx, ty;
    logic signed [glk_pkg::ZW-1:0] step;

    always_comb begin
        tx         = d.y >>> IDX;
        ty         = d.x >>> IDX;
        step       = glk_pkg::ZW'(glk_pkg::ATAN_TAB[IDX]);
        state_next = d;
        if (d.z >= 0) begin
            state_next.x = d.x - tx;
            state_next.y = d.y + ty;
            state_next.z = d.z - step;
        end else begin
            state_next.x = d.x + tx;
            state_next.y = d.y - ty;
            state_next.z = d.z + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

// ===== rtl/glk_vec_cell.sv =====
module glk_vec_cell #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                en,
    input  glk_pkg::vec_state_t d,
    output glk_pkg::vec_state_t q
);

    glk_pkg::vec_state_t state_reg, state_next;
    logic signed [glk_pkg::VW-1:0] tx, ty;
    logic signed [glk_pkg::ZW-1:0] step;

    always_comb begin
        tx         = d.y >>> IDX;
        ty         = d.x >>> IDX;
        step       = glk_pkg::ZW'(glk_pkg::ATAN_TAB[IDX]);
        state_next = d;
        if (d.y > 0) begin
            state_next.x = d.x + tx;
            state_next.y = d.y - ty;
            state_next.z = d.z + step;
        end else begin
            state_next.x = d.x - tx;
            state_next.y = d.y + ty;
            state_next.z = d.z - step;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

// ===== rtl/glk_sqrt_cell.sv =====
module glk_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  glk_pkg::sqrt_state_t d,
    output glk_pkg::sqrt_state_t q
);

    localparam logic [glk_pkg::SW-1:0] BIT = glk_pkg::SW'(1) << (2 * (glk_pkg::RB - 1 - IDX));

    glk_pkg::sqrt_state_t state_reg, state_next;
    logic [glk_pkg::SW-1:0] trial;

    always_comb begin
        trial        = d.r + BIT;
        state_next.n = d.n;
        state_next.r = d.r >> 1;
        if (d.n >= trial) begin
            state_next.n = d.n - trial;
            state_next.r = (d.r >> 1) + BIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

// ===== rtl/glk_checker.sv =====
module glk_checker #(
    parameter int FRAC_BITS = glk_pkg::FRAC_BITS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [24:0] s_raan,
    input logic [24:0] s_mean_anomaly,
    input logic        m_valid,
    input logic        m_ready,
    input logic [24:0] m_azimuth,
    input logic [23:0] m_elevation,
    input logic [23:0] m_slant_range,
    input logic        m_visible,
    input logic [2:0]  m_compass_sector,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [24:0] cfg_data
);

    localparam longint Sector = 64'd45 << FRAC_BITS;
    localparam longint SectorHalf = (64'd45 << FRAC_BITS) >> 1;

    logic [2:0] exp_sector;
    assign exp_sector = 3'((64'(m_azimuth) + SectorHalf) / Sector);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_azimuth, m_elevation,
            m_slant_range, m_visible, m_compass_sector}))
        else $error("stalled result changed");

    a_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_visible == ($signed(m_elevation) > 0))
        else $error("visible flag disagrees with elevation");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_slant_range <= 24'd12800000)
        else $error("slant range above saturation limit");

    a_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (FRAC_BITS > 16) || (m_compass_sector == exp_sector))
        else $error("compass sector disagrees with azimuth");

endmodule

bind geo_look_angle_unit glk_checker #(.FRAC_BITS(FRAC_BITS)) u_glk_checker (.*);
